// ===== design/utf8s_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8s_pkg
// Types, constants and the lead byte decode shared by the sanitizer modules.
// ----------------------------------------------------------------------------
package utf8s_pkg;

  localparam int unsigned MAX_OUT   = 6;
  localparam int unsigned CNT_W     = $clog2(MAX_OUT + 1);
  localparam int unsigned IDX_W     = $clog2(MAX_OUT);
  localparam int unsigned HOLD_D    = 3;
  localparam int unsigned HOLD_W    = $clog2(HOLD_D);
  localparam int unsigned QDEPTH    = 4;
  localparam int unsigned QPTR_W    = $clog2(QDEPTH);
  localparam int unsigned QCNT_W    = $clog2(QDEPTH + 1);

  localparam logic [7:0] ASCII_MAX  = 8'h7F;
  localparam logic [7:0] LEAD2_MIN  = 8'hC2;
  localparam logic [7:0] LEAD2_MAX  = 8'hDF;
  localparam logic [7:0] LEAD3_MIN  = 8'hE0;
  localparam logic [7:0] LEAD3_MAX  = 8'hEF;
  localparam logic [7:0] LEAD3_SURR = 8'hED;
  localparam logic [7:0] LEAD4_MIN  = 8'hF0;
  localparam logic [7:0] LEAD4_MAX  = 8'hF4;
  localparam logic [7:0] LOW_E0     = 8'hA0;
  localparam logic [7:0] HIGH_ED    = 8'h9F;
  localparam logic [7:0] LOW_F0     = 8'h90;
  localparam logic [7:0] HIGH_F4    = 8'h8F;
  localparam logic [7:0] CONT_LOW   = 8'h80;
  localparam logic [7:0] CONT_HIGH  = 8'hBF;
  localparam logic [7:0] REPL_B0    = 8'hEF;
  localparam logic [7:0] REPL_B1    = 8'hBF;
  localparam logic [7:0] REPL_B2    = 8'hBD;

  typedef enum logic [1:0] {
    LEAD_ASCII,
    LEAD_OPEN,
    LEAD_BAD
  } lead_kind_t;

  typedef struct packed {
    lead_kind_t kind;
    logic [2:0] len;
    logic [7:0] lo;
    logic [7:0] hi;
  } lead_info_t;

  // one accepted byte worth of output bytes
  typedef struct packed {
    logic [MAX_OUT-1:0][7:0] bytes;
    logic [CNT_W-1:0]        count;
    logic                    last;
  } job_t;

  function automatic lead_info_t decode_lead(input logic [7:0] b);
    lead_info_t info;
    info.kind = LEAD_BAD;
    info.len  = 3'd0;
    info.lo   = CONT_LOW;
    info.hi   = CONT_HIGH;
    if (b <= ASCII_MAX) begin
      info.kind = LEAD_ASCII;
    end else if (b >= LEAD2_MIN && b <= LEAD2_MAX) begin
      info.kind = LEAD_OPEN;
      info.len  = 3'd2;
    end else if (b >= LEAD3_MIN && b <= LEAD3_MAX) begin
      info.kind = LEAD_OPEN;
      info.len  = 3'd3;
      if (b == LEAD3_MIN) begin
        info.lo = LOW_E0;
      end else if (b == LEAD3_SURR) begin
        info.hi = HIGH_ED;
      end
    end else if (b >= LEAD4_MIN && b <= LEAD4_MAX) begin
      info.kind = LEAD_OPEN;
      info.len  = 3'd4;
      if (b == LEAD4_MIN) begin
        info.lo = LOW_F0;
      end else if (b == LEAD4_MAX) begin
        info.hi = HIGH_F4;
      end
    end
    return info;
  endfunction

endpackage

// ===== design/utf8s_in_if.sv =====
// ----------------------------------------------------------------------------
// utf8s_in_if
// Raw byte channel into the sanitizer.
// ----------------------------------------------------------------------------
interface utf8s_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       stream_last;

  modport source (output valid, output in_byte, output stream_last, input ready);
  modport sink   (input valid, input in_byte, input stream_last, output ready);
endinterface

// ===== design/utf8s_out_if.sv =====
// ----------------------------------------------------------------------------
// utf8s_out_if
// Sanitized byte channel out of the sanitizer.
// ----------------------------------------------------------------------------
interface utf8s_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       stream_done;

  modport source (output valid, output out_byte, output run_last, output stream_done,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input stream_done,
                  output ready);
endinterface

// ===== design/utf8s_front.sv =====
// ----------------------------------------------------------------------------
// utf8s_front
// Tracks the open sequence and turns each input byte that yields output bytes into one output job.
// ----------------------------------------------------------------------------
module utf8s_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  logic [7:0]          in_byte,
  input  logic                in_last,
  output logic                job_push,
  output utf8s_pkg::job_t     job
);

  logic [utf8s_pkg::HOLD_D-1:0][7:0] held_r, held_nxt;
  logic [1:0]                        hcnt_r, hcnt_nxt;
  logic [2:0]                        exp_r, exp_nxt;
  logic [7:0]                        lo_r, lo_nxt;
  logic [7:0]                        hi_r, hi_nxt;

  always_comb begin
    utf8s_pkg::lead_info_t li;
    logic [utf8s_pkg::MAX_OUT-1:0][7:0] ob;
    logic [utf8s_pkg::CNT_W-1:0] n;
    logic reopen;

    li       = utf8s_pkg::decode_lead(in_byte);
    ob       = '0;
    n        = '0;
    reopen   = 1'b0;
    held_nxt = held_r;
    hcnt_nxt = hcnt_r;
    exp_nxt  = exp_r;
    lo_nxt   = lo_r;
    hi_nxt   = hi_r;

    if (exp_r == 3'd0) begin
      reopen = 1'b1;
    end else if (in_byte >= lo_r && in_byte <= hi_r) begin
      if ({1'b0, hcnt_r} + 3'd1 >= exp_r) begin
        for (int i = 0; i < utf8s_pkg::HOLD_D; i++) begin
          if (i < int'(hcnt_r)) begin
            ob[n[utf8s_pkg::IDX_W-1:0]] = held_r[i];
            n = n + 1'b1;
          end
        end
        ob[n[utf8s_pkg::IDX_W-1:0]] = in_byte;
        n        = n + 1'b1;
        hcnt_nxt = 2'd0;
        exp_nxt  = 3'd0;
        lo_nxt   = utf8s_pkg::CONT_LOW;
        hi_nxt   = utf8s_pkg::CONT_HIGH;
      end else begin
        held_nxt[hcnt_r[utf8s_pkg::HOLD_W-1:0]] = in_byte;
        hcnt_nxt = hcnt_r + 2'd1;
        lo_nxt   = utf8s_pkg::CONT_LOW;
        hi_nxt   = utf8s_pkg::CONT_HIGH;
      end
    end else begin
      ob[0]    = utf8s_pkg::REPL_B0;
      ob[1]    = utf8s_pkg::REPL_B1;
      ob[2]    = utf8s_pkg::REPL_B2;
      n        = utf8s_pkg::CNT_W'(3);
      hcnt_nxt = 2'd0;
      exp_nxt  = 3'd0;
      lo_nxt   = utf8s_pkg::CONT_LOW;
      hi_nxt   = utf8s_pkg::CONT_HIGH;
      reopen   = 1'b1;
    end

    if (reopen) begin
      case (li.kind)
        utf8s_pkg::LEAD_ASCII: begin
          ob[n[utf8s_pkg::IDX_W-1:0]] = in_byte;
          n = n + 1'b1;
        end
        utf8s_pkg::LEAD_OPEN: begin
          held_nxt[0] = in_byte;
          hcnt_nxt    = 2'd1;
          exp_nxt     = li.len;
          lo_nxt      = li.lo;
          hi_nxt      = li.hi;
        end
        default: begin
          ob[n[utf8s_pkg::IDX_W-1:0]]        = utf8s_pkg::REPL_B0;
          ob[n[utf8s_pkg::IDX_W-1:0] + 3'd1] = utf8s_pkg::REPL_B1;
          ob[n[utf8s_pkg::IDX_W-1:0] + 3'd2] = utf8s_pkg::REPL_B2;
          n = n + utf8s_pkg::CNT_W'(3);
        end
      endcase
    end

    // end of stream flushes an open sequence
    if (in_last && exp_nxt != 3'd0) begin
      ob[n[utf8s_pkg::IDX_W-1:0]]        = utf8s_pkg::REPL_B0;
      ob[n[utf8s_pkg::IDX_W-1:0] + 3'd1] = utf8s_pkg::REPL_B1;
      ob[n[utf8s_pkg::IDX_W-1:0] + 3'd2] = utf8s_pkg::REPL_B2;
      n        = n + utf8s_pkg::CNT_W'(3);
      hcnt_nxt = 2'd0;
      exp_nxt  = 3'd0;
      lo_nxt   = utf8s_pkg::CONT_LOW;
      hi_nxt   = utf8s_pkg::CONT_HIGH;
    end

    job.bytes = ob;
    job.count = n;
    job.last  = in_last;
    job_push  = in_fire && (n != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hcnt_r <= 2'd0;
      exp_r  <= 3'd0;
      lo_r   <= utf8s_pkg::CONT_LOW;
      hi_r   <= utf8s_pkg::CONT_HIGH;
    end else if (in_fire) begin
      hcnt_r <= hcnt_nxt;
      exp_r  <= exp_nxt;
      lo_r   <= lo_nxt;
      hi_r   <= hi_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      held_r <= held_nxt;
    end
  end

endmodule

// ===== design/utf8s_queue.sv =====
// ----------------------------------------------------------------------------
// utf8s_queue
// Small job FIFO that decouples byte classification from byte emission.
// ----------------------------------------------------------------------------
module utf8s_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  utf8s_pkg::job_t push_job,
  input  logic            pop,
  output logic            full,
  output logic            empty,
  output utf8s_pkg::job_t head
);

  utf8s_pkg::job_t                 mem_r [utf8s_pkg::QDEPTH];
  logic [utf8s_pkg::QPTR_W-1:0]    wptr_r, wptr_nxt;
  logic [utf8s_pkg::QPTR_W-1:0]    rptr_r, rptr_nxt;
  logic [utf8s_pkg::QCNT_W-1:0]    cnt_r, cnt_nxt;

  assign full  = (cnt_r == utf8s_pkg::QCNT_W'(utf8s_pkg::QDEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = pop ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_job;
    end
  end

endmodule

// ===== design/utf8s_back.sv =====
// ----------------------------------------------------------------------------
// utf8s_back
// Walks the head job one byte per transaction and retires it on its last byte.
// ----------------------------------------------------------------------------
module utf8s_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  utf8s_pkg::job_t    q_head,
  output logic               q_pop,
  utf8s_out_if.source        out_ch
);

  logic [utf8s_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic                        at_end;
  logic                        fire;

  assign at_end = (utf8s_pkg::CNT_W'(idx_r) + utf8s_pkg::CNT_W'(1)) == q_head.count;
  assign fire   = out_ch.valid && out_ch.ready;

  assign out_ch.valid       = !q_empty;
  assign out_ch.out_byte    = q_head.bytes[idx_r];
  assign out_ch.run_last    = at_end;
  assign out_ch.stream_done = at_end && q_head.last;
  assign q_pop              = fire && at_end;

  always_comb begin
    idx_nxt = idx_r;
    if (fire) begin
      idx_nxt = at_end ? '0 : idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule

// ===== design/utf8_sanitizer.sv =====
// ----------------------------------------------------------------------------
// utf8_sanitizer
// Streaming UTF-8 validator that replaces ill-formed subparts with U+FFFD.
//
//   channel | dir | payload                              | transaction when
//   in_ch   | in  | in_byte, stream_last                 | valid && ready
//   out_ch  | out | out_byte, run_last, stream_done      | valid && ready
//
// one input byte is taken per cycle while the job queue has room
// each input byte yields 0 to 6 output bytes, emitted one per cycle while out_ch is ready
// well-formed text runs at one byte per cycle end to end while out_ch is ready
// four-entry job queue absorbs replacement bursts; a stalled output fills it
// reset is synchronous, active low, and closes any open sequence
// ----------------------------------------------------------------------------
module utf8_sanitizer (
  input  logic          clk,
  input  logic          rst_n,
  utf8s_in_if.sink      in_ch,
  utf8s_out_if.source   out_ch
);

  logic            q_full;
  logic            q_empty;
  logic            q_pop;
  logic            job_push;
  utf8s_pkg::job_t job;
  utf8s_pkg::job_t q_head;
  logic            in_fire;

  assign in_ch.ready = !q_full;
  assign in_fire     = in_ch.valid && in_ch.ready;

  utf8s_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_byte  (in_ch.in_byte),
    .in_last  (in_ch.stream_last),
    .job_push (job_push),
    .job      (job)
  );

  utf8s_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (job),
    .pop      (q_pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (q_head)
  );

  utf8s_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

// ===== design/utf8s_checker.sv =====
// ----------------------------------------------------------------------------
// utf8s_checker
// Port-level checks on the sanitizer output, bound to the top level.
// ----------------------------------------------------------------------------
module utf8s_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       run_last,
  input logic       stream_done
);

  // stalled transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
    $stable(run_last) && $stable(stream_done))
    else $error("output changed while stalled");

  a_done_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && stream_done |-> run_last)
    else $error("stream_done without run_last");

  // bytes that never occur in well-formed utf-8
  a_no_bad_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_byte < 8'hF5 && out_byte != 8'hC0 && out_byte != 8'hC1)
    else $error("ill-formed byte on output");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind utf8_sanitizer utf8s_checker u_utf8s_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_byte    (out_ch.out_byte),
  .run_last    (out_ch.run_last),
  .stream_done (out_ch.stream_done)
);
